>>> src/swmo_pkg.sv
// ----------------------------------------------------------------------------
// swmo_pkg
// Shared types and constants for the stack with middle-element operations.
// ----------------------------------------------------------------------------
package swmo_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DEPTH_W         = 7;
  localparam int VAL_W           = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELMID = 2'd2,
    OP_INSMID = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [VAL_W-1:0]  value_in;
  } swmo_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value_out;
    status_t                  status;
    logic [DEPTH_W-1:0]       depth_now;
  } swmo_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RM_RD,
    S_RM_CAP,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic rd_src;
    logic wr_en;
    logic wr_new;
    logic ptr_step;
    logic cnt_inc;
    logic cnt_dec;
    logic rem_load;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic refused;
    logic more;
    logic res_room;
  } dp_stat_t;

endpackage

>>> src/stack_with_middle_ops.sv
// ----------------------------------------------------------------------------
// stack_with_middle_ops
// Bounded stack of signed 32-bit values with push, pop, delete-middle and
// insert-middle requests.
// ----------------------------------------------------------------------------
//  channel  ports                          payload
//  in       in_valid / in_stall / in_data   swmo_in_t  (opcode, value_in)
//  out      out_valid / out_stall / out_data swmo_out_t (value_out, status,
//                                                        depth_now)
//
//  One request at a time through a single-port entry memory. A refused request
//  goes straight to the result; insert-middle and delete-middle also move
//  entries one at a time (up to about STACK_DEPTH/2 moves).
//  Reset clears the count, the sequencer and the result flag; the memory
//  holds no reset value.
//  A result held under out_stall keeps the next result waiting, and with it
//  every request after that one.
// ----------------------------------------------------------------------------
module stack_with_middle_ops
  import swmo_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  swmo_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output swmo_out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  swmo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swmo_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> src/swmo_ctrl.sv
// ----------------------------------------------------------------------------
// swmo_ctrl
// Sequencer: accepts a request, walks the entry shift one move at a time and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module swmo_ctrl
  import swmo_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.refused) begin
          state_nxt = S_DONE;
        end else if (stat.is_ins) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = 1'b0;
        state_nxt  = S_RM_CAP;
      end
      S_RM_CAP: begin
        cmd.rem_load = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_SH_RD: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = 1'b1;
          state_nxt  = S_SH_WR;
        end else if (stat.is_ins) begin
          state_nxt = S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_new   = 1'b0;
        cmd.ptr_step = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.res_room) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/swmo_dpath.sv
// ----------------------------------------------------------------------------
// swmo_dpath
// Entry memory, count, position pointers and the result register.
// ----------------------------------------------------------------------------
module swmo_dpath
  import swmo_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  swmo_in_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  logic      out_stall,
  output logic      out_valid,
  output swmo_out_t out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [VAL_W-1:0] mem [STACK_DEPTH];

  opcode_t                 op_r;
  logic signed [VAL_W-1:0] val_r;
  status_t                 stat_r;
  logic [CW-1:0]           cnt_r;
  logic [AW-1:0]           pos_r;
  logic [AW-1:0]           ptr_r;
  logic signed [VAL_W-1:0] rdata_r;
  logic signed [VAL_W-1:0] rem_r;
  logic                    out_valid_r;
  swmo_out_t               out_data_r;

  logic                    is_ins;
  logic                    in_is_ins;
  logic [CW:0]             cnt_p1;
  logic [CW-1:0]           cnt_m1;
  logic [AW-1:0]           pos_nxt;
  status_t                 stat_nxt;
  logic [AW-1:0]           src_addr;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;

  assign is_ins    = (op_r == OP_PUSH) || (op_r == OP_INSMID);
  assign in_is_ins = (in_data.opcode == OP_PUSH) || (in_data.opcode == OP_INSMID);
  assign cnt_p1    = {1'b0, cnt_r} + (CW+1)'(1);
  assign cnt_m1    = cnt_r - CW'(1);

  always_comb begin
    unique case (in_data.opcode)
      OP_PUSH:   pos_nxt = AW'(cnt_r);
      OP_INSMID: pos_nxt = AW'(cnt_p1 >> 1);
      OP_POP:    pos_nxt = AW'(cnt_m1);
      OP_DELMID: pos_nxt = AW'(cnt_m1 >> 1);
      default:   pos_nxt = AW'(cnt_r);
    endcase
  end

  always_comb begin
    stat_nxt = ST_OK;
    if (in_is_ins && (cnt_r == CW'(STACK_DEPTH))) begin
      stat_nxt = ST_FULL;
    end else if (!in_is_ins && (cnt_r == '0)) begin
      stat_nxt = ST_EMPTY;
    end
  end

  assign src_addr = is_ins ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
  assign raddr    = cmd.rd_src ? src_addr : pos_r;
  assign waddr    = cmd.wr_new ? pos_r : ptr_r;
  assign wdata    = cmd.wr_new ? val_r : rdata_r;

  always_comb begin
    stat          = '0;
    stat.is_ins   = is_ins;
    stat.refused  = (stat_r != ST_OK);
    stat.more     = is_ins ? (ptr_r > pos_r) : ((CW'(ptr_r) + CW'(1)) < cnt_r);
    stat.res_room = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_data.opcode;
      val_r  <= in_data.value_in;
      stat_r <= stat_nxt;
      pos_r  <= pos_nxt;
      ptr_r  <= in_is_ins ? AW'(cnt_r) : pos_nxt;
    end else if (cmd.ptr_step) begin
      ptr_r  <= src_addr;
    end
    if (cmd.rem_load) begin
      rem_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r.value_out <= (!is_ins && (stat_r == ST_OK)) ? rem_r : '0;
      out_data_r.status    <= stat_r;
      out_data_r.depth_now <= DEPTH_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
